// ----- hdl/gne_pkg.sv -----
// Shared types and constants of the gate netlist evaluator.
`timescale 1ns / 1ps
`default_nettype none

package gne_pkg;

	// Default sizes of the gate table, the value store and the output width
	localparam int MAX_GATES_DEF   = 1024;
	localparam int MAX_INPUTS_DEF  = 64;
	localparam int MAX_OUTPUTS_DEF = 64;

	// Fixed field widths
	localparam int SRC_W   = 11;
	localparam int TT_W    = 4;
	localparam int GIDX_W  = 10;
	localparam int BITS_W  = 64;
	localparam int CNT7_W  = 7;
	localparam int GCNT_W  = 11;
	localparam int CFG_W   = 11;
	localparam int CFGI_W  = 2;

	// Item commands
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_EVAL = 1'b1;

	// Configuration register indexes
	localparam logic [CFGI_W-1:0] REG_INPUT_WIDTH  = 2'd0;
	localparam logic [CFGI_W-1:0] REG_OUTPUT_WIDTH = 2'd1;
	localparam logic [CFGI_W-1:0] REG_GATE_COUNT   = 2'd2;
	localparam logic [CFGI_W-1:0] REG_TABLE_READY  = 2'd3;

	// One gate table entry
	typedef struct packed {
		logic [SRC_W-1:0] src_a;
		logic [SRC_W-1:0] src_b;
		logic [TT_W-1:0]  tt;
	} gate_entry_t;

	// Occupancy of the gate evaluation pipeline
	typedef struct packed {
		logic r_vld;
		logic w_vld;
	} gu_stat_t;

endpackage

`default_nettype wire

// ----- hdl/gne_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module gne_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ----- hdl/gne_gate_unit.sv -----
// Shared gate evaluation unit: operand read, bypass and truth table lookup.
`timescale 1ns / 1ps
`default_nettype none

module gne_gate_unit import gne_pkg::*; #(
	parameter int VAL_DEPTH = MAX_INPUTS_DEF + MAX_GATES_DEF,
	localparam int VAW = (VAL_DEPTH > 1) ? $clog2(VAL_DEPTH) : 1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           issue,
	input  logic [VAW-1:0] issue_waddr,
	input  gate_entry_t    entry,
	output logic [VAW-1:0] rd_addr_a,
	output logic [VAW-1:0] rd_addr_b,
	input  logic           rd_bit_a,
	input  logic           rd_bit_b,
	output logic           wr_en,
	output logic [VAW-1:0] wr_addr,
	output logic           wr_bit,
	output gu_stat_t       stat
);

	logic           r_vld_q;
	logic [VAW-1:0] r_waddr_q;
	logic           w_vld_q;
	logic [VAW-1:0] w_waddr_q;
	logic [TT_W-1:0] w_tt_q;
	logic           w_oor_a_q, w_oor_b_q;
	logic           w_fwd_a_q, w_fwd_b_q;
	logic           v_last_q;
	logic           oor_a, oor_b;
	logic           fwd_a, fwd_b;
	logic           op_a, op_b;

	// Operand addresses; indices past the store read as zero
	assign oor_a     = 32'(entry.src_a) >= VAL_DEPTH;
	assign oor_b     = 32'(entry.src_b) >= VAL_DEPTH;
	assign rd_addr_a = VAW'(entry.src_a);
	assign rd_addr_b = VAW'(entry.src_b);

	// Detect an operand that the gate in the write stage is writing right now
	assign fwd_a = w_vld_q && !oor_a && (rd_addr_a == w_waddr_q);
	assign fwd_b = w_vld_q && !oor_b && (rd_addr_b == w_waddr_q);

	// Advance stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_vld_q <= 1'b0;
			w_vld_q <= 1'b0;
		end else begin
			r_vld_q <= issue;
			w_vld_q <= r_vld_q;
		end
	end

	// Carry gate payload down the stages
	always_ff @(posedge clk) begin
		r_waddr_q <= issue_waddr;
		w_waddr_q <= r_waddr_q;
		w_tt_q    <= entry.tt;
		w_oor_a_q <= oor_a;
		w_oor_b_q <= oor_b;
		w_fwd_a_q <= fwd_a;
		w_fwd_b_q <= fwd_b;
		if (w_vld_q) begin
			v_last_q <= wr_bit;
		end
	end

	// Select operands and look up the truth table
	assign op_a = w_oor_a_q ? 1'b0 : (w_fwd_a_q ? v_last_q : rd_bit_a);
	assign op_b = w_oor_b_q ? 1'b0 : (w_fwd_b_q ? v_last_q : rd_bit_b);

	assign wr_bit  = w_tt_q[{op_a, op_b}];
	assign wr_en   = w_vld_q;
	assign wr_addr = w_waddr_q;

	assign stat.r_vld = r_vld_q;
	assign stat.w_vld = w_vld_q;

endmodule

`default_nettype wire

// ----- hdl/gate_netlist_evaluator_core.sv -----
// Top level of the gate netlist evaluator: registers, sequencer, stores and result register.
`timescale 1ns / 1ps
`default_nettype none

// A load item (cmd 0) writes one gate table entry in the cycle it is accepted and
// gives no result. An evaluate item (cmd 1) writes the used input bits into the value
// store one bit per cycle, then streams the gates through one shared evaluation unit
// at one gate per cycle (a registered bypass covers a gate that reads the gate just
// before it), then reads the last output gates back one bit per cycle. The phases run
// in turn, set by the single write port of the value store; an evaluate while
// table_ready is 0 skips them and goes straight to its not_ready result. The block
// takes one item at a time; a finished result waits in the output register while the
// next item is accepted. After reset all MAX_INPUTS + MAX_GATES entries (1088 by
// default) of the value store are swept to zero, and no item is accepted until the
// sweep ends.
module gate_netlist_evaluator_core import gne_pkg::*; #(
	parameter int MAX_GATES   = MAX_GATES_DEF,
	parameter int MAX_INPUTS  = MAX_INPUTS_DEF,
	parameter int MAX_OUTPUTS = MAX_OUTPUTS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CFGI_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              cmd,
	input  logic [GIDX_W-1:0] gate_index,
	input  logic [SRC_W-1:0]  source_a,
	input  logic [SRC_W-1:0]  source_b,
	input  logic [TT_W-1:0]   truth_table,
	input  logic [BITS_W-1:0] input_bits,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [BITS_W-1:0] output_bits,
	output logic              not_ready
);

	localparam int VAL_DEPTH = MAX_INPUTS + MAX_GATES;
	localparam int VAW = (VAL_DEPTH > 1) ? $clog2(VAL_DEPTH) : 1;
	localparam int GAW = (MAX_GATES > 1) ? $clog2(MAX_GATES) : 1;
	localparam int GCW = $clog2(MAX_GATES + 1);

	typedef enum logic [5:0] {
		S_CLEAR = 6'b000001,
		S_IDLE  = 6'b000010,
		S_INPUT = 6'b000100,
		S_GATE  = 6'b001000,
		S_OUT   = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

	state_t state_q;

	logic [CNT7_W-1:0] input_width_q;
	logic [CNT7_W-1:0] output_width_q;
	logic [GCNT_W-1:0] gate_count_q;
	logic              table_ready_q;

	logic [CNT7_W-1:0] ic_c;
	logic [GCW-1:0]    gc_c;
	logic [CNT7_W-1:0] oc_lim;
	logic [CNT7_W-1:0] oc_c;
	logic [VAW-1:0]    base_c;

	logic [VAW-1:0]    clr_q;
	logic [CNT7_W-1:0] in_cnt_q;
	logic [GCW-1:0]    f_q;
	logic [CNT7_W-1:0] oj_q;
	logic              o_vld_q;
	logic [5:0]        o_idx_q;
	logic [BITS_W-1:0] in_bits_q;
	logic [BITS_W-1:0] res_bits_q;
	logic              res_nr_q;
	logic              out_vld_q;
	logic [BITS_W-1:0] out_bits_q;
	logic              out_nr_q;

	logic        in_xfer;
	logic        tbl_we;
	gate_entry_t tbl_wdata;
	logic [$bits(gate_entry_t)-1:0] tbl_rdata;
	gate_entry_t entry;
	logic        gate_issue;
	logic        out_issue;
	logic        out_load;

	logic           v_we;
	logic [VAW-1:0] v_waddr;
	logic           v_wbit;
	logic [VAW-1:0] v_raddr_a;
	logic           v_rbit_a;
	logic           v_rbit_b;

	logic [VAW-1:0] gu_addr_a;
	logic [VAW-1:0] gu_addr_b;
	logic           gu_we;
	logic [VAW-1:0] gu_waddr;
	logic           gu_wbit;
	gu_stat_t       gu_stat;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			input_width_q  <= CNT7_W'(1);
			output_width_q <= CNT7_W'(1);
			gate_count_q   <= GCNT_W'(1);
			table_ready_q  <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_INPUT_WIDTH:  input_width_q  <= cfg_data[CNT7_W-1:0];
				REG_OUTPUT_WIDTH: output_width_q <= cfg_data[CNT7_W-1:0];
				REG_GATE_COUNT:   gate_count_q   <= cfg_data[GCNT_W-1:0];
				REG_TABLE_READY:  table_ready_q  <= cfg_data[0];
			endcase
		end
	end

	// Saturate the sizes into their ranges
	always_comb begin
		if (input_width_q == '0) begin
			ic_c = CNT7_W'(1);
		end else if (32'(input_width_q) > MAX_INPUTS) begin
			ic_c = CNT7_W'(MAX_INPUTS);
		end else begin
			ic_c = input_width_q;
		end

		if (gate_count_q == '0) begin
			gc_c = GCW'(1);
		end else if (32'(gate_count_q) > MAX_GATES) begin
			gc_c = GCW'(MAX_GATES);
		end else begin
			gc_c = GCW'(gate_count_q);
		end

		if (output_width_q == '0) begin
			oc_lim = CNT7_W'(1);
		end else if (32'(output_width_q) > MAX_OUTPUTS) begin
			oc_lim = CNT7_W'(MAX_OUTPUTS);
		end else begin
			oc_lim = output_width_q;
		end

		if (32'(oc_lim) > 32'(gc_c)) begin
			oc_c = CNT7_W'(gc_c);
		end else begin
			oc_c = oc_lim;
		end

		base_c = VAW'(ic_c) + VAW'(gc_c) - VAW'(oc_c);
	end

	assign in_stall = (state_q != S_IDLE);
	assign in_xfer  = in_valid && !in_stall;

	// Gate table: written by load items, read in gate order
	assign tbl_we          = in_xfer && (cmd == CMD_LOAD) && (32'(gate_index) < MAX_GATES);
	assign tbl_wdata.src_a = source_a;
	assign tbl_wdata.src_b = source_b;
	assign tbl_wdata.tt    = truth_table;
	assign entry           = gate_entry_t'(tbl_rdata);

	gne_ram #(
		.WIDTH ($bits(gate_entry_t)),
		.DEPTH (MAX_GATES)
	) u_tbl_ram (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (GAW'(gate_index)),
		.wdata (tbl_wdata),
		.raddr (f_q[GAW-1:0]),
		.rdata (tbl_rdata)
	);

	assign gate_issue = (state_q == S_GATE) && (f_q < gc_c);
	assign out_issue  = (state_q == S_OUT) && (oj_q < oc_c);

	gne_gate_unit #(
		.VAL_DEPTH (VAL_DEPTH)
	) u_gate_unit (
		.clk         (clk),
		.arst_n      (arst_n),
		.issue       (gate_issue),
		.issue_waddr (VAW'(ic_c) + VAW'(f_q)),
		.entry       (entry),
		.rd_addr_a   (gu_addr_a),
		.rd_addr_b   (gu_addr_b),
		.rd_bit_a    (v_rbit_a),
		.rd_bit_b    (v_rbit_b),
		.wr_en       (gu_we),
		.wr_addr     (gu_waddr),
		.wr_bit      (gu_wbit),
		.stat        (gu_stat)
	);

	// Share the value store write port between clear, input and gate phases
	always_comb begin
		v_we    = 1'b0;
		v_waddr = gu_waddr;
		v_wbit  = gu_wbit;
		unique case (state_q)
			S_CLEAR: begin
				v_we    = 1'b1;
				v_waddr = clr_q;
				v_wbit  = 1'b0;
			end
			S_INPUT: begin
				v_we    = 1'b1;
				v_waddr = VAW'(in_cnt_q);
				v_wbit  = in_bits_q[in_cnt_q[5:0]];
			end
			S_GATE: begin
				v_we = gu_we;
			end
			default: begin
				v_we = 1'b0;
			end
		endcase
	end

	assign v_raddr_a = (state_q == S_OUT) ? (base_c + VAW'(oj_q)) : gu_addr_a;

	// Value store, kept as two copies for two operand reads a cycle
	gne_ram #(
		.WIDTH (1),
		.DEPTH (VAL_DEPTH)
	) u_val_ram_a (
		.clk   (clk),
		.we    (v_we),
		.waddr (v_waddr),
		.wdata (v_wbit),
		.raddr (v_raddr_a),
		.rdata (v_rbit_a)
	);

	gne_ram #(
		.WIDTH (1),
		.DEPTH (VAL_DEPTH)
	) u_val_ram_b (
		.clk   (clk),
		.we    (v_we),
		.waddr (v_waddr),
		.wdata (v_wbit),
		.raddr (gu_addr_b),
		.rdata (v_rbit_b)
	);

	assign out_load = (state_q == S_DONE) && (!out_vld_q || !out_stall);

	// Sequencer and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			clr_q    <= '0;
			in_cnt_q <= '0;
			f_q      <= '0;
			oj_q     <= '0;
			o_vld_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + VAW'(1);
					if (clr_q == VAW'(VAL_DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_xfer && (cmd == CMD_EVAL)) begin
						in_cnt_q <= '0;
						state_q  <= table_ready_q ? S_INPUT : S_DONE;
					end
				end
				S_INPUT: begin
					in_cnt_q <= in_cnt_q + CNT7_W'(1);
					if (in_cnt_q == ic_c - CNT7_W'(1)) begin
						f_q     <= '0;
						state_q <= S_GATE;
					end
				end
				S_GATE: begin
					if (gate_issue) begin
						f_q <= f_q + GCW'(1);
					end else if (!gu_stat.r_vld && !gu_stat.w_vld) begin
						oj_q    <= '0;
						o_vld_q <= 1'b0;
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					o_vld_q <= out_issue;
					if (out_issue) begin
						oj_q <= oj_q + CNT7_W'(1);
					end else if (!o_vld_q) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
			endcase
		end
	end

	// Hold input bits and gather result bits
	always_ff @(posedge clk) begin
		o_idx_q <= oj_q[5:0];
		if (in_xfer && (cmd == CMD_EVAL)) begin
			in_bits_q  <= input_bits;
			res_bits_q <= '0;
			res_nr_q   <= !table_ready_q;
		end else if ((state_q == S_OUT) && o_vld_q) begin
			res_bits_q[o_idx_q] <= v_rbit_a;
		end
	end

	// Output register: load a finished result, drop it once transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_load) begin
			out_vld_q <= 1'b1;
		end else if (out_vld_q && !out_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_bits_q <= res_bits_q;
			out_nr_q   <= res_nr_q;
		end
	end

	assign out_valid   = out_vld_q;
	assign output_bits = out_bits_q;
	assign not_ready   = out_nr_q;

endmodule

`default_nettype wire

// ----- hdl/gne_checker.sv -----
// Port-level checks of the gate netlist evaluator, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none

module gne_checker import gne_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              cmd,
	input logic              out_valid,
	input logic              out_stall,
	input logic [BITS_W-1:0] output_bits,
	input logic              not_ready
);

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(output_bits) && $stable(not_ready))
		else $error("stalled result changed");

	// A not-ready result carries no output bits
	a_nr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && not_ready |-> output_bits == '0)
		else $error("not_ready result with nonzero bits");

	// An evaluate transfer makes the block busy
	a_eval_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (cmd == CMD_EVAL) |=> in_stall)
		else $error("block not busy after evaluate");

	// A load transfer leaves the block ready for the next item
	a_load_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (cmd == CMD_LOAD) |=> !in_stall)
		else $error("block busy after load");

endmodule

bind gate_netlist_evaluator_core gne_checker u_gne_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.cmd         (cmd),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.output_bits (output_bits),
	.not_ready   (not_ready)
);

`default_nettype wire

// ----- test/tb.sv -----
// Self-checking testbench of the gate netlist evaluator core.
`timescale 1ns / 1ps

module tb;
	import gne_pkg::*;

	localparam int VALUE_DEPTH    = MAX_INPUTS_DEF + MAX_GATES_DEF;
	localparam int WATCHDOG_LIMIT = 10000;
	localparam int RANDOM_PHASES  = 9;
	localparam int LARGE_GATES    = 192;
	localparam int SETTLE_CYCLES  = 16;
	localparam int DRAIN_CYCLES   = 1200;

	typedef struct {
		logic              cmd;
		logic [GIDX_W-1:0] gidx;
		logic [SRC_W-1:0]  src_a;
		logic [SRC_W-1:0]  src_b;
		logic [TT_W-1:0]   tt;
		logic [BITS_W-1:0] bits;
	} net_item_t;

	typedef struct {
		logic [BITS_W-1:0] bits;
		logic              not_ready;
	} net_result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic [CFGI_W-1:0] cfg_index = REG_INPUT_WIDTH;
	logic [CFG_W-1:0]  cfg_data = '0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic              cmd = CMD_LOAD;
	logic [GIDX_W-1:0] gate_index = '0;
	logic [SRC_W-1:0]  source_a = '0;
	logic [SRC_W-1:0]  source_b = '0;
	logic [TT_W-1:0]   truth_table = '0;
	logic [BITS_W-1:0] input_bits = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [BITS_W-1:0] output_bits;
	logic              not_ready;

	// Item backlog and outstanding expectations
	net_item_t   item_backlog[$];
	net_result_t awaited_results[$];
	int          items_in_flight = 0;
	int          mismatch_count = 0;
	int          quiet_cycles = 0;
	bit          in_taken = 1'b0;
	bit          no_idling = 1'b0;
	int          send_gap = 0;
	int          stall_left = 0;

	// Shadow of the block: registers, gate table and value store
	logic [CNT7_W-1:0] model_in_w = 7'd1;
	logic [CNT7_W-1:0] model_out_w = 7'd1;
	logic [GCNT_W-1:0] model_gates = 11'd1;
	logic              model_ready = 1'b0;
	bit [SRC_W-1:0]    gate_src_a[MAX_GATES_DEF];
	bit [SRC_W-1:0]    gate_src_b[MAX_GATES_DEF];
	bit [TT_W-1:0]     gate_tt[MAX_GATES_DEF];
	bit                value_store[VALUE_DEPTH];

	// Stimulus bookkeeping: gates planned for loading so far and the current input width
	bit planned[MAX_GATES_DEF];
	int plan_ic = 1;

	gate_netlist_evaluator_core i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.cmd         (cmd),
		.gate_index  (gate_index),
		.source_a    (source_a),
		.source_b    (source_b),
		.truth_table (truth_table),
		.input_bits  (input_bits),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.output_bits (output_bits),
		.not_ready   (not_ready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int clamp_int(input int v, input int lo, input int hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function automatic bit store_bit(input int idx);
		if (idx >= VALUE_DEPTH)
			return 1'b0;
		return value_store[idx];
	endfunction

	// Run the gate network on one evaluate transfer and queue its result
	task automatic evaluate_network(input logic [BITS_W-1:0] bits);
		int ic;
		int gc;
		int oc;
		int base;
		bit a;
		bit b;
		net_result_t r;
		if (!model_ready) begin
			r.bits = '0;
			r.not_ready = 1'b1;
			awaited_results.push_back(r);
			return;
		end
		ic = clamp_int(int'(model_in_w), 1, MAX_INPUTS_DEF);
		gc = clamp_int(int'(model_gates), 1, MAX_GATES_DEF);
		oc = clamp_int(int'(model_out_w), 1, MAX_OUTPUTS_DEF);
		if (oc > gc)
			oc = gc;
		for (int i = 0; i < ic; i++)
			value_store[i] = bits[i];
		for (int g = 0; g < gc; g++) begin
			a = store_bit(int'(gate_src_a[g]));
			b = store_bit(int'(gate_src_b[g]));
			value_store[ic + g] = gate_tt[g][{a, b}];
		end
		base = ic + gc - oc;
		r.bits = '0;
		r.not_ready = 1'b0;
		for (int j = 0; j < oc; j++)
			r.bits[j] = store_bit(base + j);
		awaited_results.push_back(r);
	endtask

	// Feed items at the falling edge; hold a stalled item until it is taken
	always @(negedge clk) begin : feed
		net_item_t nxt;
		if (arst_n && !(in_valid && !in_taken)) begin
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				in_valid <= 1'b0;
			end else if (item_backlog.size() == 0) begin
				in_valid <= 1'b0;
			end else if (!no_idling && $urandom_range(0, 7) == 0) begin
				send_gap <= $urandom_range(0, 18);
				in_valid <= 1'b0;
			end else begin
				nxt = item_backlog.pop_front();
				cmd <= nxt.cmd;
				gate_index <= nxt.gidx;
				source_a <= nxt.src_a;
				source_b <= nxt.src_b;
				truth_table <= nxt.tt;
				input_bits <= nxt.bits;
				in_valid <= 1'b1;
			end
		end
	end

	// Stall the result side in random bursts
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else if (!no_idling && $urandom_range(0, 9) == 0) begin
			stall_left <= $urandom_range(0, 18);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Track register writes, predict on each input transfer, check each result transfer
	always @(posedge clk) begin : track
		net_result_t want;
		bit in_fire;
		bit out_fire;
		in_fire = in_valid && !in_stall;
		out_fire = out_valid && !out_stall;
		in_taken <= in_fire;
		if (arst_n) begin
			if (cfg_we) begin
				case (cfg_index)
					REG_INPUT_WIDTH: model_in_w = cfg_data[CNT7_W-1:0];
					REG_OUTPUT_WIDTH: model_out_w = cfg_data[CNT7_W-1:0];
					REG_GATE_COUNT: model_gates = cfg_data[GCNT_W-1:0];
					REG_TABLE_READY: model_ready = cfg_data[0];
					default: ;
				endcase
			end
			if (in_fire) begin
				items_in_flight--;
				if (cmd == CMD_LOAD) begin
					gate_src_a[gate_index] = source_a;
					gate_src_b[gate_index] = source_b;
					gate_tt[gate_index] = truth_table;
				end else begin
					evaluate_network(input_bits);
				end
			end
			if (out_fire) begin
				if (awaited_results.size() == 0) begin
					$error("result with nothing awaited: output_bits %h not_ready %b",
						output_bits, not_ready);
					mismatch_count++;
				end else begin
					want = awaited_results.pop_front();
					if (output_bits !== want.bits) begin
						$error("output_bits: expected %h, actual %h", want.bits, output_bits);
						mismatch_count++;
					end
					if (not_ready !== want.not_ready) begin
						$error("not_ready: expected %b, actual %b", want.not_ready, not_ready);
						mismatch_count++;
					end
				end
			end
			// Drop the run if nothing moves for too long
			if (in_fire || out_fire)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	task automatic push_load(input int gi, input int a, input int b, input int tt);
		net_item_t it;
		it.cmd = CMD_LOAD;
		it.gidx = gi[GIDX_W-1:0];
		it.src_a = a[SRC_W-1:0];
		it.src_b = b[SRC_W-1:0];
		it.tt = tt[TT_W-1:0];
		it.bits = {$urandom, $urandom};
		planned[gi] = 1'b1;
		items_in_flight++;
		item_backlog.push_back(it);
	endtask

	task automatic push_eval(input logic [BITS_W-1:0] bits);
		net_item_t it;
		it.cmd = CMD_EVAL;
		it.gidx = GIDX_W'($urandom_range(0, MAX_GATES_DEF - 1));
		it.src_a = SRC_W'($urandom_range(0, 2047));
		it.src_b = SRC_W'($urandom_range(0, 2047));
		it.tt = TT_W'($urandom_range(0, 15));
		it.bits = bits;
		items_in_flight++;
		item_backlog.push_back(it);
	endtask

	// Mostly feed-forward sources, sometimes anywhere in the store or beyond it
	function automatic int pick_source(input int g);
		int k;
		k = $urandom_range(0, 9);
		if (k < 8)
			return $urandom_range(0, plan_ic + g - 1);
		if (k == 8)
			return $urandom_range(0, VALUE_DEPTH - 1);
		return $urandom_range(0, 2047);
	endfunction

	function automatic logic [BITS_W-1:0] random_bits();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// Wait until every item is taken and every result is back
	task automatic pause_for_idle();
		while (items_in_flight != 0 || awaited_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_reg(input logic [CFGI_W-1:0] idx, input int val);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val[CFG_W-1:0];
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// Reprogram all registers while idle, then load any gate below the new count not yet planned
	task automatic apply_config(input int iw, input int ow, input int gc, input int rdy);
		int plan_gc;
		pause_for_idle();
		set_reg(REG_INPUT_WIDTH, iw);
		set_reg(REG_OUTPUT_WIDTH, ow);
		set_reg(REG_GATE_COUNT, gc);
		set_reg(REG_TABLE_READY, rdy);
		plan_ic = clamp_int(iw & 'h7F, 1, MAX_INPUTS_DEF);
		plan_gc = clamp_int(gc & 'h7FF, 1, MAX_GATES_DEF);
		for (int g = 0; g < plan_gc; g++)
			if (!planned[g])
				push_load(g, pick_source(g), pick_source(g), $urandom_range(0, 15));
	endtask

	function automatic int pick_width();
		case ($urandom_range(0, 19))
			0: return 0;
			1: return 127;
			2: return $urandom_range(17, 2047);
			default: return $urandom_range(1, 16);
		endcase
	endfunction

	initial begin
		int iw;
		int ow;
		int gc;
		int gi;
		int n_items;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// Directed: not-ready evaluate at reset settings, then a small known network
		push_eval('1);
		push_load(0, 0, 1, 4'b1000);
		push_load(1, 2047, 2047, 4'b0001);
		push_load(2, 4, 3, 4'b0110);
		push_load(3, 7, 2, 4'b0110);
		push_load(MAX_GATES_DEF - 1, 2047, 0, 4'b1111);
		apply_config(1, 1, 1, 1);
		push_eval('0);
		push_eval(64'h1);
		apply_config(4, 2, 4, 1);
		push_eval('0);
		push_eval('1);
		push_eval(64'h5);
		push_eval(64'hA);
		push_eval(64'hFFFF_FFFF_FFFF_FFF0);
		apply_config(0, 0, 0, 1);
		push_eval(64'h1);
		apply_config(2, 100, 3, 1);
		push_eval(64'h2);
		apply_config(4, 2, 4, 0);
		push_eval(64'hF);

		// Random phases with small networks; one phase also runs a larger network at the widest inputs and outputs
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			if (p == RANDOM_PHASES / 2) begin
				apply_config(2047, 2047, LARGE_GATES, 1);
				repeat (4) push_eval(random_bits());
				apply_config(64, 64, LARGE_GATES, 1);
				repeat (2) push_eval(random_bits());
			end
			iw = pick_width();
			ow = pick_width();
			case ($urandom_range(0, 19))
				0: gc = 0;
				1: gc = $urandom_range(25, 64);
				default: gc = $urandom_range(1, 24);
			endcase
			apply_config(iw, ow, gc, ($urandom_range(0, 9) != 0));
			no_idling = (p >= RANDOM_PHASES - 2);
			gc = clamp_int(gc & 'h7FF, 1, MAX_GATES_DEF);
			n_items = $urandom_range(30, 50);
			for (int k = 0; k < n_items; k++) begin
				case ($urandom_range(0, 9))
					0, 1: begin
						gi = $urandom_range(0, gc - 1);
						push_load(gi, pick_source(gi), pick_source(gi), $urandom_range(0, 15));
					end
					2: begin
						gi = $urandom_range(0, MAX_GATES_DEF - 1);
						push_load(gi, pick_source(gi), pick_source(gi), $urandom_range(0, 15));
					end
					default: push_eval(random_bits());
				endcase
			end
		end

		// Let the last results arrive and watch for strays
		pause_for_idle();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (awaited_results.size() != 0) begin
			$error("%0d results never arrived", awaited_results.size());
			mismatch_count++;
		end
		if (mismatch_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
